// ===== rtl/pmc_pkg.sv =====
// pmc_pkg: shared types, register indexes and default constants for the PID move controller.
// No dependencies; every other file in rtl/ imports this package.
package pmc_pkg;

	// defaults for the top-level parameters
	localparam int SETTLE_COUNT_DEF   = 20;
	localparam int POS_BITS_DEF       = 24;
	localparam int GAIN_FRAC_BITS_DEF = 8;

	localparam int GAIN_BITS     = 16;
	localparam int INTEG_BITS    = 17;
	localparam int COUNT_BITS    = 8;
	localparam int ELAPSED_BITS  = 16;
	localparam int OLIM_BITS     = 7;
	localparam int DRIVE_BITS    = 8;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_P      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_I      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_D      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_INT_BAND    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_INT_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE_TOL  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT     = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_LIM  = 3'd7;

	// register reset values
	localparam logic [COUNT_BITS-1:0]   SETTLE_TOL_RST  = 8'd3;
	localparam logic [ELAPSED_BITS-1:0] TIMEOUT_RST     = 16'd3000;
	localparam logic [OLIM_BITS-1:0]    OUTPUT_LIM_RST  = 7'd127;

	localparam logic [COUNT_BITS-1:0]   COUNT_MAX       = '1;
	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX     = '1;
	localparam logic signed [DRIVE_BITS-1:0] DRIVE_NEG_FULL = 8'sh80;

	typedef struct packed {
		logic [GAIN_BITS-1:0]    gain_p;
		logic [GAIN_BITS-1:0]    gain_i;
		logic [GAIN_BITS-1:0]    gain_d;
		logic [GAIN_BITS-1:0]    integrate_band;
		logic [GAIN_BITS-1:0]    integral_limit;
		logic [COUNT_BITS-1:0]   settle_tolerance;
		logic [ELAPSED_BITS-1:0] timeout_ticks;
		logic [OLIM_BITS-1:0]    output_limit;
	} cfg_t;

	// running move state, all but the previous error
	typedef struct packed {
		logic                          move_done;
		logic [COUNT_BITS-1:0]         settle_count;
		logic [ELAPSED_BITS-1:0]       elapsed_ticks;
		logic signed [INTEG_BITS-1:0]  integral_sum;
	} move_state_t;

	typedef struct packed {
		logic settled;
		logic timed_out;
	} move_flags_t;

endpackage

// ===== rtl/pmc_if.sv =====
// pmc_if: valid/ready channel interfaces for control ticks in and drive results out.
// Depends on pmc_pkg.
interface pmc_in_if #(
	parameter int POS_BITS = pmc_pkg::POS_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic                       start_req;
	logic signed [POS_BITS-1:0] setpoint;
	logic signed [POS_BITS-1:0] measured;

	modport source (output valid, output start_req, output setpoint, output measured,
		input ready);
	modport sink (input valid, input start_req, input setpoint, input measured,
		output ready);
endinterface

interface pmc_out_if #(
	parameter int POS_BITS = pmc_pkg::POS_BITS_DEF
);
	import pmc_pkg::*;
	logic                         valid;
	logic                         ready;
	logic signed [DRIVE_BITS-1:0] drive;
	logic signed [POS_BITS:0]     position_error;
	logic                         settled;
	logic                         timed_out;

	modport source (output valid, output drive, output position_error, output settled,
		output timed_out, input ready);
	modport sink (input valid, input drive, input position_error, input settled,
		input timed_out, output ready);
endinterface

// ===== rtl/pid_move_controller.sv =====
// pid_move_controller: top level: config registers, tick input register, move state and
// result register around pmc_core. Depends on pmc_pkg, pmc_if and pmc_core.
//
//  channel  | dir | handshake     | word
//  in_ch    | in  | valid/ready   | start_req, setpoint, measured
//  out_ch   | out | valid/ready   | drive, position_error, settled, timed_out
//  cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// One tick per cycle unless the output stalls: a word is held in the input register,
// the whole tick is worked out from there into the result register, which is offered
// once the tick has left the input register. The move state is updated at that point,
// so the next tick sees it straight away. arst_n resets state, valids and config.
// A stalled output holds its word; one more tick waits in the input register.
module pid_move_controller #(
	parameter int SETTLE_COUNT   = pmc_pkg::SETTLE_COUNT_DEF,
	parameter int POS_BITS       = pmc_pkg::POS_BITS_DEF,
	parameter int GAIN_FRAC_BITS = pmc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	pmc_in_if.sink                             in_ch,
	pmc_out_if.source                          out_ch,
	input  logic                               cfg_we,
	input  logic [pmc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [pmc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import pmc_pkg::*;

	cfg_t                       cfg_q;
	move_state_t                state_q;
	move_state_t                state_nxt;
	logic signed [POS_BITS:0]   prev_err_q;
	logic signed [POS_BITS:0]   prev_err_nxt;

	logic                       valid_s1;
	logic                       start_s1;
	logic signed [POS_BITS-1:0] setpoint_s1;
	logic signed [POS_BITS-1:0] measured_s1;

	logic                       out_valid_q;
	logic signed [DRIVE_BITS-1:0] drive_q;
	logic signed [POS_BITS:0]   perr_q;
	move_flags_t                flags_q;

	logic signed [DRIVE_BITS-1:0] drive_c;
	logic signed [POS_BITS:0]   perr_c;
	move_flags_t                flags_c;
	logic                       advance;

	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p           <= '0;
			cfg_q.gain_i           <= '0;
			cfg_q.gain_d           <= '0;
			cfg_q.integrate_band   <= '0;
			cfg_q.integral_limit   <= '0;
			cfg_q.settle_tolerance <= SETTLE_TOL_RST;
			cfg_q.timeout_ticks    <= TIMEOUT_RST;
			cfg_q.output_limit     <= OUTPUT_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P:     cfg_q.gain_p           <= cfg_data;
				REG_GAIN_I:     cfg_q.gain_i           <= cfg_data;
				REG_GAIN_D:     cfg_q.gain_d           <= cfg_data;
				REG_INT_BAND:   cfg_q.integrate_band   <= cfg_data;
				REG_INT_LIMIT:  cfg_q.integral_limit   <= cfg_data;
				REG_SETTLE_TOL: cfg_q.settle_tolerance <= cfg_data[COUNT_BITS-1:0];
				REG_TIMEOUT:    cfg_q.timeout_ticks    <= cfg_data;
				REG_OUTPUT_LIM: cfg_q.output_limit     <= cfg_data[OLIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			start_s1    <= in_ch.start_req;
			setpoint_s1 <= in_ch.setpoint;
			measured_s1 <= in_ch.measured;
		end
	end

	pmc_core #(
		.SETTLE_COUNT   (SETTLE_COUNT),
		.POS_BITS       (POS_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_core (
		.cfg            (cfg_q),
		.state_cur      (state_q),
		.prev_err_cur   (prev_err_q),
		.start_req      (start_s1),
		.setpoint       (setpoint_s1),
		.measured       (measured_s1),
		.state_nxt      (state_nxt),
		.prev_err_nxt   (prev_err_nxt),
		.drive          (drive_c),
		.position_error (perr_c),
		.flags          (flags_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= '0;
			prev_err_q <= '0;
		end else if (advance) begin
			state_q    <= state_nxt;
			prev_err_q <= prev_err_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= drive_c;
			perr_q  <= perr_c;
			flags_q <= flags_c;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.drive          = drive_q;
	assign out_ch.position_error = perr_q;
	assign out_ch.settled        = flags_q.settled;
	assign out_ch.timed_out      = flags_q.timed_out;

endmodule

// ===== rtl/pmc_core.sv =====
// pmc_core: one control tick in combinational logic: error, clamped integral, PID sum,
// saturation, settle and timeout tracking. Depends on pmc_pkg.
module pmc_core #(
	parameter int SETTLE_COUNT   = pmc_pkg::SETTLE_COUNT_DEF,
	parameter int POS_BITS       = pmc_pkg::POS_BITS_DEF,
	parameter int GAIN_FRAC_BITS = pmc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  pmc_pkg::cfg_t                    cfg,
	input  pmc_pkg::move_state_t             state_cur,
	input  logic signed [POS_BITS:0]         prev_err_cur,
	input  logic                             start_req,
	input  logic signed [POS_BITS-1:0]       setpoint,
	input  logic signed [POS_BITS-1:0]       measured,
	output pmc_pkg::move_state_t             state_nxt,
	output logic signed [POS_BITS:0]         prev_err_nxt,
	output logic signed [pmc_pkg::DRIVE_BITS-1:0] drive,
	output logic signed [POS_BITS:0]         position_error,
	output pmc_pkg::move_flags_t             flags
);
	import pmc_pkg::*;

	localparam int EW = POS_BITS + 1;
	localparam int DW = POS_BITS + 2;
	localparam int AW = ((EW > INTEG_BITS) ? EW : INTEG_BITS) + 1;
	localparam int MW = (DW > INTEG_BITS) ? DW : INTEG_BITS;
	localparam int PW = MW + GAIN_BITS + 1;
	localparam int SW = PW + 2;

	move_state_t             st;
	logic signed [EW-1:0]    prev_err;
	logic signed [EW-1:0]    err;
	logic [EW-1:0]           mag_err;
	logic                    in_band;
	logic signed [AW-1:0]    int_raw;
	logic signed [AW-1:0]    int_lim;
	logic signed [INTEG_BITS-1:0] int_new;
	logic signed [DW-1:0]    diff;
	logic signed [PW-1:0]    prod_p;
	logic signed [PW-1:0]    prod_i;
	logic signed [PW-1:0]    prod_d;
	logic signed [SW-1:0]    sum;
	logic [SW-1:0]           mag_sum;
	logic [SW-1:0]           mag_shr;
	logic [OLIM_BITS-1:0]    mag_sat;
	logic signed [DRIVE_BITS-1:0] drive_act;
	logic [COUNT_BITS-1:0]   settle_new;
	logic [ELAPSED_BITS-1:0] elapsed_new;
	logic                    settled_new;
	logic                    late;

	always_comb begin
		// a start clears the running state ahead of this tick
		st       = state_cur;
		prev_err = prev_err_cur;
		if (start_req) begin
			st       = '0;
			prev_err = '0;
		end

		err     = EW'(setpoint) - EW'(measured);
		mag_err = err[EW-1] ? EW'(-err) : EW'(err);
		in_band = {{GAIN_BITS{1'b0}}, mag_err} < {{EW{1'b0}}, cfg.integrate_band};

		int_raw = in_band ? (AW'(st.integral_sum) + AW'(err)) : '0;
		int_lim = $signed({{(AW-GAIN_BITS){1'b0}}, cfg.integral_limit});
		if (int_raw > int_lim)
			int_raw = int_lim;
		if (int_raw < -int_lim)
			int_raw = -int_lim;
		int_new = INTEG_BITS'(int_raw);

		diff   = DW'(err) - DW'(prev_err);
		prod_p = PW'($signed({1'b0, cfg.gain_p}) * err);
		prod_i = PW'($signed({1'b0, cfg.gain_i}) * int_new);
		prod_d = PW'($signed({1'b0, cfg.gain_d}) * diff);
		sum    = SW'(prod_p) + SW'(prod_i) + SW'(prod_d);

		// scale on the magnitude so the fraction drop truncates toward zero
		mag_sum = sum[SW-1] ? SW'(-sum) : SW'(sum);
		mag_shr = mag_sum >> GAIN_FRAC_BITS;
		if (mag_shr > SW'(cfg.output_limit))
			mag_sat = cfg.output_limit;
		else
			mag_sat = mag_shr[OLIM_BITS-1:0];
		drive_act = sum[SW-1] ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});

		// error is always wider than the tolerance
		settle_new = st.settle_count;
		if (mag_err <= EW'(cfg.settle_tolerance) && st.settle_count != COUNT_MAX)
			settle_new = st.settle_count + 1'b1;
		settled_new = settle_new >= COUNT_BITS'(SETTLE_COUNT);
		late        = st.elapsed_ticks > cfg.timeout_ticks;
		elapsed_new = (st.elapsed_ticks != ELAPSED_MAX) ? st.elapsed_ticks + 1'b1
			: st.elapsed_ticks;

		position_error = err;
		if (st.move_done) begin
			// frozen: hold state, drive off, flags against the current registers
			state_nxt       = st;
			prev_err_nxt    = prev_err;
			drive           = '0;
			flags.settled   = st.settle_count >= COUNT_BITS'(SETTLE_COUNT);
			flags.timed_out = late;
		end else begin
			state_nxt.move_done     = settled_new || late;
			state_nxt.settle_count  = settle_new;
			state_nxt.elapsed_ticks = elapsed_new;
			state_nxt.integral_sum  = int_new;
			prev_err_nxt            = err;
			drive                   = drive_act;
			flags.settled           = settled_new;
			flags.timed_out         = elapsed_new > cfg.timeout_ticks;
		end
	end

endmodule

// ===== rtl/pmc_checker.sv =====
// pmc_checker: port-level checks on the PID move controller, bound to the top level.
// Depends on pmc_pkg and pid_move_controller.
module pmc_checker #(
	parameter int POS_BITS = pmc_pkg::POS_BITS_DEF
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [pmc_pkg::DRIVE_BITS-1:0]  drive,
	input logic signed [POS_BITS:0]               position_error
);
	import pmc_pkg::*;

	// input side only stalls when a finished word is waiting
	a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output register");

	// drive is saturated symmetrically, never the full negative code
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive != DRIVE_NEG_FULL)
		else $error("drive outside +/-127");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(position_error))
		else $error("stalled output word changed");

	// a word taken from the output lets the input register move on
	a_take_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !in_ready |-> in_valid)
		else $error("input stalled while the output word was taken");

	a_take_frees_input_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input stalled while the output word was taken");

endmodule

bind pid_move_controller pmc_checker #(
	.POS_BITS (POS_BITS)
) u_pmc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.drive          (out_ch.drive),
	.position_error (out_ch.position_error)
);

// ===== test/pid_move_controller_tb.sv =====
// pid_move_controller_tb: self-checking bench for the PID move controller: random and directed
// control ticks against an in-bench model of the move state. Needs pmc_pkg, pmc_if and the RTL.
`timescale 1ns / 100ps

module pid_move_controller_tb;
	import pmc_pkg::*;

	localparam int     CLK_PERIOD  = 20;
	localparam int     POS_W       = POS_BITS_DEF;
	localparam int     SETTLE_N    = SETTLE_COUNT_DEF;
	localparam int     FRAC_W      = GAIN_FRAC_BITS_DEF;
	localparam longint POS_MAX     = (longint'(1) <<< (POS_W - 1)) - 1;
	localparam longint POS_MIN     = -POS_MAX - 1;
	localparam int     CYCLE_LIMIT = 200_000;
	localparam int     HOLD_AFTER  = 300;
	localparam int     HOLD_LEN    = 400;
	localparam int     PRINT_MAX   = 50;

	typedef struct {
		logic                    start_req;
		logic signed [POS_W-1:0] setpoint;
		logic signed [POS_W-1:0] measured;
	} tick_t;

	typedef struct {
		logic signed [DRIVE_BITS-1:0] drive;
		logic signed [POS_W:0]        position_error;
		logic                         settled;
		logic                         timed_out;
	} move_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	pmc_in_if  in_ch ();
	pmc_out_if out_ch ();

	pid_move_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// register copy and move state as the block should hold them
	cfg_t                         regs;
	logic signed [POS_W:0]        last_err;
	logic signed [INTEG_BITS-1:0] integ;
	logic [COUNT_BITS-1:0]        settle_cnt;
	logic [ELAPSED_BITS-1:0]      elapsed;
	logic                         done;

	tick_t        pending_ticks[$];
	move_result_t expected_results[$];

	int ticks_driven = 0;
	int results_seen = 0;
	int settled_seen = 0;
	int timeouts_seen = 0;
	int mismatches = 0;
	int settings_used = 0;
	int cycle_count = 0;

	function automatic move_result_t step_move(tick_t t);
		move_result_t r;
		longint e, mag_e, isum, lim, sum, mag, olim;
		if (t.start_req) begin
			last_err = '0;
			integ = '0;
			settle_cnt = '0;
			elapsed = '0;
			done = 1'b0;
		end
		e = longint'(t.setpoint) - longint'(t.measured);
		mag_e = (e < 0) ? -e : e;
		r.drive = '0;
		if (!done) begin
			isum = integ;
			if (mag_e < longint'(regs.integrate_band))
				isum = isum + e;
			else
				isum = 0;
			lim = longint'(regs.integral_limit);
			if (isum > lim) isum = lim;
			if (isum < -lim) isum = -lim;
			integ = isum[INTEG_BITS-1:0];

			sum = longint'(regs.gain_p) * e + longint'(regs.gain_i) * isum
				+ longint'(regs.gain_d) * (e - longint'(last_err));
			// scaling drops fraction bits of the magnitude, so it rounds toward zero
			mag = ((sum < 0) ? -sum : sum) >> FRAC_W;
			olim = longint'(regs.output_limit);
			if (mag > olim) mag = olim;
			r.drive = DRIVE_BITS'((sum < 0) ? -mag : mag);

			if (mag_e <= longint'(regs.settle_tolerance) && settle_cnt != COUNT_MAX)
				settle_cnt++;
			// elapsed count as it stood before this tick
			if (settle_cnt >= SETTLE_N || elapsed > regs.timeout_ticks)
				done = 1'b1;
			if (elapsed != ELAPSED_MAX)
				elapsed++;
			last_err = (POS_W + 1)'(e);
		end
		r.position_error = (POS_W + 1)'(e);
		r.settled = (settle_cnt >= SETTLE_N);
		r.timed_out = (elapsed > regs.timeout_ticks);
		return r;
	endfunction

	task automatic log_mismatch(string what);
		mismatches++;
		if (mismatches <= PRINT_MAX)
			$display("[%0t] mismatch at result %0d: %s", $time, results_seen, what);
	endtask

	// sender: bursts of words with random gaps between them
	always @(posedge clk or negedge arst_n) begin
		tick_t nxt;
		tick_t taken;
		int    gap_left;
		int    burst_left;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.start_req <= 1'b0;
			in_ch.setpoint <= '0;
			in_ch.measured <= '0;
			gap_left = 0;
			burst_left = 1;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				taken.start_req = in_ch.start_req;
				taken.setpoint = in_ch.setpoint;
				taken.measured = in_ch.measured;
				expected_results.push_back(step_move(taken));
				ticks_driven++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0 || pending_ticks.size() == 0) begin
					in_ch.valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end else begin
					nxt = pending_ticks.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.start_req <= nxt.start_req;
					in_ch.setpoint <= nxt.setpoint;
					in_ch.measured <= nxt.measured;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// receiver: stall rate changes every so often, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		move_result_t want;
		int           stall_pct;
		int           pattern_left;
		int           hold_left;
		bit           hold_used;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_pct = 0;
			pattern_left = 0;
			hold_left = 0;
			hold_used = 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (out_ch.settled) settled_seen++;
				if (out_ch.timed_out) timeouts_seen++;
				if (expected_results.size() == 0) begin
					log_mismatch("word arrived with nothing pending");
				end else begin
					want = expected_results.pop_front();
					if (out_ch.drive !== want.drive)
						log_mismatch($sformatf("drive %0d, expected %0d",
							out_ch.drive, want.drive));
					if (out_ch.position_error !== want.position_error)
						log_mismatch($sformatf("position_error %0d, expected %0d",
							out_ch.position_error, want.position_error));
					if (out_ch.settled !== want.settled)
						log_mismatch($sformatf("settled %0b, expected %0b",
							out_ch.settled, want.settled));
					if (out_ch.timed_out !== want.timed_out)
						log_mismatch($sformatf("timed_out %0b, expected %0b",
							out_ch.timed_out, want.timed_out));
				end
			end
			if (pattern_left == 0) begin
				pattern_left = $urandom_range(16, 96);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end else begin
				pattern_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (!hold_used && results_seen >= HOLD_AFTER) begin
				// long hold-off: the block fills and has to stall its input
				hold_used = 1'b1;
				hold_left = HOLD_LEN;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_GAIN_P:     regs.gain_p = val;
			REG_GAIN_I:     regs.gain_i = val;
			REG_GAIN_D:     regs.gain_d = val;
			REG_INT_BAND:   regs.integrate_band = val;
			REG_INT_LIMIT:  regs.integral_limit = val;
			REG_SETTLE_TOL: regs.settle_tolerance = val[COUNT_BITS-1:0];
			REG_TIMEOUT:    regs.timeout_ticks = val;
			REG_OUTPUT_LIM: regs.output_limit = val[OLIM_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_regs(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
		logic [15:0] band, logic [15:0] ilim, logic [15:0] tol, logic [15:0] tmo,
		logic [15:0] olim);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_INT_BAND, band);
		write_reg(REG_INT_LIMIT, ilim);
		write_reg(REG_SETTLE_TOL, tol);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_OUTPUT_LIM, olim);
		settings_used++;
		@(negedge clk);
	endtask

	// wait until every word is out and checked, then let the pipeline go quiet
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_ticks.size() != 0 || in_ch.valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic add_tick(logic s, longint sp, longint ms);
		tick_t t;
		t.start_req = s;
		t.setpoint = sp[POS_W-1:0];
		t.measured = ms[POS_W-1:0];
		pending_ticks.push_back(t);
	endtask

	// one move converging on a target, with the odd restart and some jitter
	task automatic add_move(int len);
		logic signed [POS_W-1:0] target_r;
		longint target, err, ms;
		int     jig;
		target_r = POS_W'($urandom);
		target = target_r;
		case ($urandom_range(0, 2))
			0: err = $urandom_range(0, 40);
			1: err = $urandom_range(0, 5000);
			default: err = $urandom_range(0, 16777215);
		endcase
		if ($urandom_range(0, 1) == 1) err = -err;
		for (int i = 0; i < len; i++) begin
			ms = target - err;
			if (ms > POS_MAX) ms = POS_MAX;
			if (ms < POS_MIN) ms = POS_MIN;
			add_tick(i == 0 || $urandom_range(0, 39) == 0, target, ms);
			err = err * 3 / 4;
			if ($urandom_range(0, 3) == 0) begin
				jig = $urandom_range(0, 4);
				err = err + jig - 2;
			end
		end
	endtask

	task automatic add_random_ticks(int n);
		logic [POS_W-1:0] a, b;
		int               queued;
		int               len;
		queued = 0;
		while (queued < n) begin
			if ($urandom_range(0, 9) < 8) begin
				len = $urandom_range(5, 50);
				if (len > n - queued) len = n - queued;
				add_move(len);
				queued += len;
			end else begin
				a = POS_W'($urandom);
				b = POS_W'($urandom);
				add_tick($urandom_range(0, 1) == 1, $signed(a), $signed(b));
				queued++;
			end
		end
	endtask

	// half the words, a full drain with the sender paused, then the rest
	task automatic run_random(int n);
		add_random_ticks(n / 2);
		wait_idle();
		add_random_ticks(n - n / 2);
		wait_idle();
	endtask

	// never within tolerance 0, so the move runs on until its timeout
	task automatic add_long_move(int len);
		longint target, err;
		target = longint'($urandom_range(0, 100000)) - 50000;
		for (int i = 0; i < len; i++) begin
			err = $urandom_range(1, 3000);
			if ($urandom_range(0, 1) == 1) err = -err;
			add_tick(i == 0, target, target - err);
		end
	endtask

	initial begin
		regs = '0;
		regs.settle_tolerance = SETTLE_TOL_RST;
		regs.timeout_ticks = TIMEOUT_RST;
		regs.output_limit = OUTPUT_LIM_RST;
		last_err = '0;
		integ = '0;
		settle_cnt = '0;
		elapsed = '0;
		done = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes, integral band and clamp, timeout and the frozen move
		load_regs(16'h0100, 16'h0080, 16'h0040, 16'd100, 16'd50, 16'd3, 16'd6, 16'd127);
		add_tick(1'b1, POS_MAX, POS_MIN);
		add_tick(1'b0, POS_MIN, POS_MAX);
		add_tick(1'b0, 0, 0);
		add_tick(1'b0, 1000, 950);
		add_tick(1'b0, 1000, 920);
		add_tick(1'b0, -500, -401);
		add_tick(1'b0, 7, -93);
		add_tick(1'b0, 3, 0);
		add_tick(1'b0, 0, -4);
		add_tick(1'b1, -3, 0);
		add_tick(1'b0, 0, 4);
		wait_idle();

		// zero limits and band; output limit written with bits above its width
		load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd3000, 16'hFF80);
		add_tick(1'b1, 1000, 0);
		add_tick(1'b0, -1000, 0);
		add_tick(1'b0, 0, 0);
		wait_idle();

		// zero timeout, widest tolerance (masked from a wider word)
		load_regs(16'h0800, 16'h0010, 16'h0000, 16'd300, 16'hFFFF, 16'h01FF, 16'd0, 16'd60);
		add_tick(1'b1, 255, 0);
		add_tick(1'b0, 0, 256);
		add_tick(1'b0, 0, 0);
		add_tick(1'b1, -255, 0);
		wait_idle();

		load_regs(16'h0180, 16'h0020, 16'h0200, 16'd400, 16'd3000, 16'd3, 16'd80, 16'd127);
		run_random(200);
		load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF,
			16'h007F);
		run_random(200);
		load_regs(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
		run_random(200);

		// a move that only ends on its timeout; afterwards the frozen state is
		// re-read with the timeout raised above and dropped below the count
		load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'd0, 16'd100, 16'($urandom));
		add_long_move(120);
		wait_idle();
		write_reg(REG_TIMEOUT, 16'd500);
		@(negedge clk);
		add_tick(1'b0, 100, 0);
		add_tick(1'b0, -100, 0);
		add_tick(1'b0, 0, 5);
		wait_idle();
		write_reg(REG_TIMEOUT, 16'd40);
		@(negedge clk);
		add_tick(1'b0, 7, 0);
		add_tick(1'b0, 0, 0);
		wait_idle();

		load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		run_random(200);
		load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom_range(0, 200)), 16'($urandom));
		run_random(200);

		$display("%0d ticks under %0d register settings, one move run out to its timeout",
			ticks_driven, settings_used);
		$display("%0d words checked: %0d settled, %0d timed out, %0d mismatches",
			results_seen, settled_seen, timeouts_seen, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
